[src/dta_pkg.sv]
// Shared constants, codes and types for the descriptor table allocator.
package dta_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int REF_BITS      = 48;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // Fixed field widths of the stream beats.
  localparam int KIND_W    = 2;
  localparam int DESC_W    = 8;
  localparam int OBJ_W     = 48;
  localparam int STATUS_W  = 2;
  localparam int GRANT_W   = 6;
  localparam int TOTAL_W   = 7;
  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 64;

  typedef enum logic [KIND_W-1:0] {
    KIND_RESERVE = 2'd0,
    KIND_INSERT  = 2'd1,
    KIND_LOOKUP  = 2'd2,
    KIND_FREE    = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_BAD_FD  = 2'd2
  } status_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;  // latch the request beat and start the store read
    logic exec;     // apply the request and load the result register
  } dta_cmd_t;

endpackage

[src/dta_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/dta_ctrl.sv]
// Request sequencer: handshakes and the capture/execute steps.
module dta_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output dta_pkg::dta_cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;
  logic   out_free;
  logic   exec;

  // Take a beat whenever the capture register is free.
  assign s_ready_o = (state_q == ST_IDLE);
  assign accept    = s_valid_i && s_ready_o;

  // Hold the captured beat until the result register is empty or draining now.
  assign out_free  = !out_valid_q || m_ready_i;
  assign exec      = (state_q == ST_EXEC) && out_free;

  assign cmd_o.capture = accept;
  assign cmd_o.exec    = exec;
  assign m_valid_o     = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (exec) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

[src/dta_dpath.sv]
// Table state, lowest-free search, reference store and result register.
module dta_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dta_pkg::dta_cmd_t               cmd_i,
  input  dta_pkg::kind_e                  kind_i,
  input  logic [dta_pkg::DESC_W-1:0]      descriptor_i,
  input  logic                            close_on_exec_i,
  input  logic [dta_pkg::OBJ_W-1:0]       object_ref_i,
  output dta_pkg::status_e                status_o,
  output logic [dta_pkg::GRANT_W-1:0]     granted_o,
  output logic [dta_pkg::OBJ_W-1:0]       found_ref_o,
  output logic [dta_pkg::TOTAL_W-1:0]     open_total_o
);

  localparam int N = dta_pkg::TABLE_ENTRIES;

  // Latched request
  dta_pkg::kind_e                  kind_q;
  logic [dta_pkg::DESC_W-1:0]      desc_q;
  logic                            coe_q;
  logic [dta_pkg::REF_BITS-1:0]    obj_q;

  // Table state
  logic [N-1:0]                    open_marks_q, open_marks_d;
  logic [N-1:0]                    coe_marks_q, coe_marks_d;
  logic [N-1:0]                    ref_valid_q, ref_valid_d;
  logic [dta_pkg::CNT_W-1:0]       count_q, count_d;

  // Result register
  dta_pkg::status_e                status_q, status_d;
  logic [dta_pkg::GRANT_W-1:0]     granted_q, granted_d;
  logic [dta_pkg::OBJ_W-1:0]       found_q, found_d;
  logic [dta_pkg::TOTAL_W-1:0]     total_q;

  logic [dta_pkg::REF_BITS-1:0]    ram_rdata;
  logic [dta_pkg::REF_BITS-1:0]    stored;
  logic [dta_pkg::IDX_W-1:0]       idx;
  logic [dta_pkg::IDX_W-1:0]       pick;
  logic                            any_free;
  logic                            in_range;
  logic                            desc_ok;
  logic                            ram_we;

  assign idx      = desc_q[dta_pkg::IDX_W-1:0];
  assign in_range = {1'b0, desc_q} < (dta_pkg::DESC_W+1)'(N);
  assign desc_ok  = in_range && open_marks_q[idx];
  assign stored   = ref_valid_q[idx] ? ram_rdata : '0;
  assign any_free = ~&open_marks_q;
  assign ram_we   = cmd_i.exec && (kind_q == dta_pkg::KIND_INSERT) && desc_ok;

  dta_ram #(
    .WIDTH (dta_pkg::REF_BITS),
    .DEPTH (N)
  ) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx),
    .wdata_i (obj_q),
    .re_i    (cmd_i.capture),
    .raddr_i (descriptor_i[dta_pkg::IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Lowest clear open mark
  always_comb begin
    pick = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!open_marks_q[i]) begin
        pick = dta_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    open_marks_d = open_marks_q;
    coe_marks_d  = coe_marks_q;
    ref_valid_d  = ref_valid_q;
    count_d      = count_q;
    status_d     = dta_pkg::STATUS_OK;
    granted_d    = desc_q[dta_pkg::GRANT_W-1:0];
    found_d      = '0;
    if (kind_q == dta_pkg::KIND_RESERVE) begin
      if (any_free) begin
        open_marks_d[pick] = 1'b1;
        if (coe_q) begin
          coe_marks_d[pick] = 1'b1;
        end
        count_d   = count_q + 1'b1;
        granted_d = dta_pkg::GRANT_W'(pick);
      end else begin
        status_d  = dta_pkg::STATUS_FULL;
        granted_d = '0;
      end
    end else if (!desc_ok) begin
      status_d = dta_pkg::STATUS_BAD_FD;
    end else begin
      unique case (kind_q)
        dta_pkg::KIND_INSERT: begin
          ref_valid_d[idx] = 1'b1;
        end
        dta_pkg::KIND_LOOKUP: begin
          found_d = dta_pkg::OBJ_W'(stored);
        end
        dta_pkg::KIND_FREE: begin
          found_d           = dta_pkg::OBJ_W'(stored);
          ref_valid_d[idx]  = 1'b0;
          open_marks_d[idx] = 1'b0;
          coe_marks_d[idx]  = 1'b0;
          if (count_q != '0) begin
            count_d = count_q - 1'b1;
          end
        end
        default: begin
          found_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      desc_q <= descriptor_i;
      coe_q  <= close_on_exec_i;
      obj_q  <= dta_pkg::REF_BITS'(object_ref_i);
    end
    if (cmd_i.exec) begin
      status_q  <= status_d;
      granted_q <= granted_d;
      found_q   <= found_d;
      total_q   <= dta_pkg::TOTAL_W'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_marks_q <= '0;
      coe_marks_q  <= '0;
      ref_valid_q  <= '0;
      count_q      <= '0;
    end else if (cmd_i.exec) begin
      open_marks_q <= open_marks_d;
      coe_marks_q  <= coe_marks_d;
      ref_valid_q  <= ref_valid_d;
      count_q      <= count_d;
    end
  end

  assign status_o     = status_q;
  assign granted_o    = granted_q;
  assign found_ref_o  = found_q;
  assign open_total_o = total_q;

endmodule

[src/descriptor_table_allocator.sv]
// Descriptor table allocator: top level with stream ports.
//
// A table of 64 descriptors serving reserve (lowest free descriptor),
// insert, lookup and free requests, one result beat per request beat.
// Each request passes a capture step, which latches the beat and reads the
// reference RAM at the requested descriptor, and then an apply step, which
// applies the request and loads the result register that offers the result.
// The apply step waits while the previous result is still waiting to be
// taken; one request is then held in the capture register and the input
// stalls behind it. A new request beat is taken only once the previous one
// has been applied; the registered read of the reference RAM is why the
// steps are separate. The table is clear after reset with no sweep:
// per-entry valid bits stand in for the cleared reference store.
module descriptor_table_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // descriptor[7:0], close_on_exec[8], object_ref[56:9], zero fill [63:57]
  input  logic [dta_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // kind[1:0]
  input  logic [dta_pkg::KIND_W-1:0]    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // granted[5:0], found_ref[53:6], open_total[60:54], zero fill [63:61]
  output logic [dta_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  // status[1:0]
  output logic [dta_pkg::STATUS_W-1:0]  m_axis_tuser_o
);

  dta_pkg::dta_cmd_t               cmd;
  dta_pkg::status_e                status;
  logic [dta_pkg::GRANT_W-1:0]     granted;
  logic [dta_pkg::OBJ_W-1:0]       found_ref;
  logic [dta_pkg::TOTAL_W-1:0]     open_total;

  dta_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .cmd_o     (cmd)
  );

  dta_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .kind_i          (dta_pkg::kind_e'(s_axis_tuser_i)),
    .descriptor_i    (s_axis_tdata_i[7:0]),
    .close_on_exec_i (s_axis_tdata_i[8]),
    .object_ref_i    (s_axis_tdata_i[56:9]),
    .status_o        (status),
    .granted_o       (granted),
    .found_ref_o     (found_ref),
    .open_total_o    (open_total)
  );

  assign m_axis_tdata_o = {3'b000, open_total, found_ref, granted};
  assign m_axis_tuser_o = status;

endmodule

[sim/tb.sv]
// Self-checking stream testbench for the descriptor table allocator.
module tb;

  localparam int N_RANDOM = 1100;

  typedef struct packed {
    dta_pkg::status_e              status;
    logic [dta_pkg::GRANT_W-1:0]   granted;
    logic [dta_pkg::OBJ_W-1:0]     found_ref;
    logic [dta_pkg::TOTAL_W-1:0]   open_total;
  } fd_reply_t;

  // Table model plus the queue of replies it predicts.
  class fd_table_scoreboard;
    logic                      open_map    [dta_pkg::TABLE_ENTRIES];
    logic                      cloexec_map [dta_pkg::TABLE_ENTRIES];
    logic [dta_pkg::OBJ_W-1:0] ref_tbl     [dta_pkg::TABLE_ENTRIES];
    int unsigned               live_count;
    fd_reply_t                 pending_replies[$];
    int unsigned               mismatches;

    function new();
      for (int i = 0; i < dta_pkg::TABLE_ENTRIES; i++) begin
        open_map[i]    = 1'b0;
        cloexec_map[i] = 1'b0;
        ref_tbl[i]     = '0;
      end
      live_count = 0;
      mismatches = 0;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
    endfunction

    function void note_request(dta_pkg::kind_e kind, logic [dta_pkg::DESC_W-1:0] desc,
                               logic coe, logic [dta_pkg::OBJ_W-1:0] obj);
      fd_reply_t r;
      int        pick;
      r.status     = dta_pkg::STATUS_OK;
      r.granted    = desc[dta_pkg::GRANT_W-1:0];
      r.found_ref  = '0;
      pick         = dta_pkg::TABLE_ENTRIES;
      if (kind == dta_pkg::KIND_RESERVE) begin
        for (int i = dta_pkg::TABLE_ENTRIES - 1; i >= 0; i--)
          if (!open_map[i]) pick = i;
        if (pick < dta_pkg::TABLE_ENTRIES) begin
          open_map[pick] = 1'b1;
          if (coe) cloexec_map[pick] = 1'b1;
          live_count++;
          r.granted = pick[dta_pkg::GRANT_W-1:0];
        end else begin
          r.status  = dta_pkg::STATUS_FULL;
          r.granted = '0;
        end
      end else if (desc >= dta_pkg::TABLE_ENTRIES || !open_map[desc]) begin
        r.status = dta_pkg::STATUS_BAD_FD;
      end else if (kind == dta_pkg::KIND_INSERT) begin
        ref_tbl[desc] = obj;
      end else if (kind == dta_pkg::KIND_LOOKUP) begin
        r.found_ref = ref_tbl[desc];
      end else begin
        r.found_ref       = ref_tbl[desc];
        ref_tbl[desc]     = '0;
        open_map[desc]    = 1'b0;
        cloexec_map[desc] = 1'b0;
        if (live_count > 0) live_count--;
      end
      r.open_total = live_count[dta_pkg::TOTAL_W-1:0];
      pending_replies.push_back(r);
    endfunction

    function void check_reply(dta_pkg::status_e st, logic [dta_pkg::GRANT_W-1:0] g,
                              logic [dta_pkg::OBJ_W-1:0] f,
                              logic [dta_pkg::TOTAL_W-1:0] t);
      fd_reply_t e;
      if (pending_replies.size() == 0) begin
        report($sformatf("unexpected beat: status %0d granted %0d ref %h total %0d",
                         st, g, f, t));
        return;
      end
      e = pending_replies.pop_front();
      if (e.status !== st)
        report($sformatf("status: expected %0d, got %0d", e.status, st));
      if (e.granted !== g)
        report($sformatf("granted: expected %0d, got %0d", e.granted, g));
      if (e.found_ref !== f)
        report($sformatf("found_ref: expected %h, got %h", e.found_ref, f));
      if (e.open_total !== t)
        report($sformatf("open_total: expected %0d, got %0d", e.open_total, t));
    endfunction
  endclass

  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b0;
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  logic [dta_pkg::S_TDATA_W-1:0] s_axis_tdata_i  = '0;
  logic [dta_pkg::KIND_W-1:0]    s_axis_tuser_i  = '0;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  logic [dta_pkg::M_TDATA_W-1:0] m_axis_tdata_o;
  logic [dta_pkg::STATUS_W-1:0]  m_axis_tuser_o;

  fd_table_scoreboard sb = new();
  int unsigned        burst_left = 4;

  descriptor_table_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: switch between free-running, light, heavy and blocky stalls.
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  int unsigned rx_tick = 0;
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(3);
      rx_left = $urandom_range(300, 50);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      0:       m_axis_tready_i <= 1'b1;
      1:       m_axis_tready_i <= ($urandom_range(3) != 0);
      2:       m_axis_tready_i <= ($urandom_range(3) == 0);
      default: m_axis_tready_i <= rx_tick[3];
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_reply(dta_pkg::status_e'(m_axis_tuser_o), m_axis_tdata_o[5:0],
                     m_axis_tdata_o[53:6], m_axis_tdata_o[60:54]);
  end

  // Call at a falling edge; returns at a falling edge once the beat is accepted.
  task automatic send_beat(dta_pkg::kind_e kind, logic [dta_pkg::DESC_W-1:0] desc,
                           logic coe, logic [dta_pkg::OBJ_W-1:0] obj);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {7'b0, obj, coe, desc};
    s_axis_tuser_i  <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(kind, desc, coe, obj);
    @(negedge clk_i);
    if (burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(8, 1)) @(negedge clk_i);
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(60, 20) : $urandom_range(8);
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [dta_pkg::OBJ_W-1:0] random_ref();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return {{(dta_pkg::OBJ_W-1){1'b0}}, 1'b1} << $urandom_range(dta_pkg::OBJ_W - 1);
      default: return raw[dta_pkg::OBJ_W-1:0];
    endcase
  endfunction

  // Favor open descriptors so most requests reach the table.
  function automatic logic [dta_pkg::DESC_W-1:0] random_desc();
    int unsigned r;
    int unsigned start;
    int unsigned idx;
    r = $urandom_range(99);
    if (r < 80 && sb.live_count > 0) begin
      start = $urandom_range(dta_pkg::TABLE_ENTRIES - 1);
      for (int i = 0; i < dta_pkg::TABLE_ENTRIES; i++) begin
        idx = (start + i) % dta_pkg::TABLE_ENTRIES;
        if (sb.open_map[idx]) return idx[dta_pkg::DESC_W-1:0];
      end
    end
    if (r < 92) return dta_pkg::DESC_W'($urandom_range(dta_pkg::TABLE_ENTRIES - 1));
    return dta_pkg::DESC_W'($urandom_range(255));
  endfunction

  function automatic dta_pkg::kind_e random_kind(int unsigned phase);
    int unsigned r;
    r = $urandom_range(99);
    case (phase)
      0: return (r < 75) ? dta_pkg::KIND_RESERVE : (r < 85) ? dta_pkg::KIND_INSERT :
                (r < 95) ? dta_pkg::KIND_LOOKUP : dta_pkg::KIND_FREE;
      1: return (r < 10) ? dta_pkg::KIND_RESERVE : (r < 25) ? dta_pkg::KIND_INSERT :
                (r < 45) ? dta_pkg::KIND_LOOKUP : dta_pkg::KIND_FREE;
      default: return (r < 30) ? dta_pkg::KIND_RESERVE : (r < 55) ? dta_pkg::KIND_INSERT :
                      (r < 80) ? dta_pkg::KIND_LOOKUP : dta_pkg::KIND_FREE;
    endcase
  endfunction

  initial begin
    int unsigned phase;
    int unsigned phase_len;
    int unsigned issued;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Empty table, then reserve, insert, replace, lookup and free by hand.
    send_beat(dta_pkg::KIND_LOOKUP,  8'd0,   1'b1, 48'h0);
    send_beat(dta_pkg::KIND_INSERT,  8'd0,   1'b0, '1);
    send_beat(dta_pkg::KIND_FREE,    8'd0,   1'b1, '1);
    send_beat(dta_pkg::KIND_RESERVE, 8'd0,   1'b1, '1);
    send_beat(dta_pkg::KIND_RESERVE, 8'd255, 1'b0, 48'h0);
    send_beat(dta_pkg::KIND_LOOKUP,  8'd0,   1'b0, '1);
    send_beat(dta_pkg::KIND_INSERT,  8'd0,   1'b0, '1);
    send_beat(dta_pkg::KIND_LOOKUP,  8'd0,   1'b1, 48'h0);
    send_beat(dta_pkg::KIND_INSERT,  8'd0,   1'b1, 48'h1);
    send_beat(dta_pkg::KIND_LOOKUP,  8'd0,   1'b0, 48'h0);
    send_beat(dta_pkg::KIND_INSERT,  8'd1,   1'b0, 48'h8000_0000_0000);
    send_beat(dta_pkg::KIND_LOOKUP,  8'd64,  1'b0, 48'h0);
    send_beat(dta_pkg::KIND_FREE,    8'd255, 1'b0, 48'h0);
    send_beat(dta_pkg::KIND_INSERT,  8'd128, 1'b1, 48'h5555_AAAA_5555);
    send_beat(dta_pkg::KIND_LOOKUP,  8'd63,  1'b0, 48'h0);
    send_beat(dta_pkg::KIND_FREE,    8'd0,   1'b0, 48'h0);
    send_beat(dta_pkg::KIND_LOOKUP,  8'd0,   1'b0, 48'h0);
    send_beat(dta_pkg::KIND_RESERVE, 8'd200, 1'b1, 48'hAAAA_5555_AAAA);
    send_beat(dta_pkg::KIND_FREE,    8'd1,   1'b1, 48'h0);
    send_beat(dta_pkg::KIND_RESERVE, 8'd63,  1'b0, 48'h0);
    send_beat(dta_pkg::KIND_FREE,    8'd1,   1'b0, 48'h0);
    send_beat(dta_pkg::KIND_FREE,    8'd0,   1'b0, 48'h0);

    // Random fill, drain and mixed phases; a fill phase can run into the full table.
    issued = 0;
    while (issued < N_RANDOM) begin
      phase     = $urandom_range(2);
      phase_len = $urandom_range(150, 20);
      for (int i = 0; i < phase_len && issued < N_RANDOM; i++) begin
        send_beat(random_kind(phase), random_desc(), 1'($urandom_range(1)), random_ref());
        issued++;
      end
    end

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
